/* rtl/core/ffd_pkg.sv */
// Shared types, constants and the CRC-8 step for the fixed frame deframer.
package ffd_pkg;

	// Largest number of words one frame can release.
	localparam int unsigned RESULT_LIMIT = 16;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned PW_W    = 5;
	localparam int unsigned BC_W    = 7;
	localparam int unsigned CNT_W   = 5;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 5;
	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_WORDS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_CHECK     = 1'd1;

	// Framing bytes and CRC polynomial
	localparam logic [BYTE_W-1:0] HEAD0    = 8'hFF;
	localparam logic [BYTE_W-1:0] HEAD1    = 8'hFC;
	localparam logic [BYTE_W-1:0] TAIL0    = 8'hA1;
	localparam logic [BYTE_W-1:0] TAIL1    = 8'hA2;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

	// Frame release request from the parser to the drain unit
	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] count;
	} rel_t;

	// CRC-8, MSB first, no reflection, no final xor
	function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
	                                                input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/ffd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ffd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/ffd_parse.sv */
// Frame parser: header/tail hunt, CRC-8, word assembly and payload RAM writes.
module ffd_parse #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       accept,
	input  logic [ffd_pkg::BYTE_W-1:0]                 rx_byte,
	input  logic [ffd_pkg::PW_W-1:0]                   payload_words,
	input  logic                                       crc_check,
	output logic                                       wr_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	output logic [ffd_pkg::WORD_W-1:0]                 wr_data,
	output ffd_pkg::rel_t                              rel
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] PH_HUNT0 = 3'd0;
	localparam logic [2:0] PH_HUNT1 = 3'd1;
	localparam logic [2:0] PH_DATA  = 3'd2;
	localparam logic [2:0] PH_CRC   = 3'd3;
	localparam logic [2:0] PH_TAIL0 = 3'd4;
	localparam logic [2:0] PH_TAIL1 = 3'd5;

	logic [2:0]                      phase_q, phase_d;
	logic [ffd_pkg::BC_W-1:0]        bc_q, bc_d, bc_inc;
	logic [ffd_pkg::BYTE_W-1:0]      crc_q, crc_d, crc_nx;
	logic [ffd_pkg::BYTE_W-1:0]      rcrc_q, rcrc_d;
	logic [3*ffd_pkg::BYTE_W-1:0]    asm_q;
	logic [ffd_pkg::PW_W-1:0]        eff_words;
	logic [ffd_pkg::BC_W-1:0]        end_count;
	ffd_pkg::rel_t                   rel_d;

	// Clamp the words-per-frame register to 1..DEPTH
	always_comb begin
		if (payload_words == '0) begin
			eff_words = ffd_pkg::PW_W'(1);
		end else if (payload_words > ffd_pkg::PW_W'(DEPTH)) begin
			eff_words = ffd_pkg::PW_W'(DEPTH);
		end else begin
			eff_words = payload_words;
		end
	end

	assign end_count = {eff_words, 2'b00};
	assign bc_inc    = bc_q + ffd_pkg::BC_W'(1);
	assign crc_nx    = ffd_pkg::crc8_next(crc_q, rx_byte);

	always_comb begin
		phase_d   = phase_q;
		bc_d      = bc_q;
		crc_d     = crc_q;
		rcrc_d    = rcrc_q;
		rel_d     = '0;
		wr_en     = 1'b0;
		wr_addr   = bc_q[AW+1:2];
		wr_data   = {rx_byte, asm_q};
		if (accept) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == ffd_pkg::HEAD1) begin
						phase_d = PH_DATA;
						bc_d    = '0;
						crc_d   = '0;
						rcrc_d  = '0;
					end else begin
						phase_d = PH_HUNT0;
					end
				end
				PH_DATA: begin
					wr_en = (bc_q[1:0] == 2'd3);
					crc_d = crc_nx;
					bc_d  = bc_inc;
					if (bc_inc >= end_count) begin
						if (crc_check) begin
							phase_d = PH_CRC;
						end else begin
							rcrc_d  = crc_nx;
							phase_d = PH_TAIL0;
						end
					end
				end
				PH_CRC: begin
					rcrc_d  = rx_byte;
					phase_d = PH_TAIL0;
				end
				PH_TAIL0: begin
					phase_d = (rx_byte == ffd_pkg::TAIL0) ? PH_TAIL1 : PH_HUNT0;
				end
				PH_TAIL1: begin
					phase_d = PH_HUNT0;
					if (rx_byte == ffd_pkg::TAIL1 && rcrc_q == crc_q) begin
						rel_d.go    = 1'b1;
						rel_d.count = bc_q[ffd_pkg::BC_W-1:2];
					end
				end
				default: begin
					phase_d = (rx_byte == ffd_pkg::HEAD0) ? PH_HUNT1 : PH_HUNT0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			bc_q    <= '0;
			crc_q   <= '0;
			rcrc_q  <= '0;
		end else begin
			phase_q <= phase_d;
			bc_q    <= bc_d;
			crc_q   <= crc_d;
			rcrc_q  <= rcrc_d;
		end
	end

	// Low three bytes of the word in progress; the fourth goes straight to RAM
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_DATA) begin
			case (bc_q[1:0])
				2'd0:    asm_q[7:0]   <= rx_byte;
				2'd1:    asm_q[15:8]  <= rx_byte;
				2'd2:    asm_q[23:16] <= rx_byte;
				default: asm_q        <= asm_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel <= '0;
		end else begin
			rel <= rel_d;
		end
	end

endmodule

/* rtl/core/ffd_drain.sv */
// Drain unit: reads released words from the payload RAM into the output register.
module ffd_drain #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  ffd_pkg::rel_t                              rel,
	output logic                                       busy,
	output logic                                       rd_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  logic [ffd_pkg::WORD_W-1:0]                 rd_data,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [ffd_pkg::INDEX_W-1:0]                out_index,
	output logic [ffd_pkg::WORD_W-1:0]                 out_value,
	output logic                                       out_last
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                          drain_q;
	logic [ffd_pkg::CNT_W-1:0]     idx_q, cnt_q, idx_inc;
	logic                          pend_s1, last_s1;
	logic [ffd_pkg::INDEX_W-1:0]   idx_s1;
	logic                          out_valid_q;
	logic                          issue, last_issue;

	// One read in flight at a time; it lands in an output register that is free
	assign issue      = drain_q && !pend_s1 && (!out_valid_q || out_ready);
	assign idx_inc    = idx_q + ffd_pkg::CNT_W'(1);
	assign last_issue = (idx_inc == cnt_q);
	assign rd_en      = issue;
	assign rd_addr    = idx_q[AW-1:0];
	assign busy       = drain_q;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (rel.go) begin
				drain_q <= 1'b1;
				idx_q   <= '0;
				cnt_q   <= rel.count;
			end else if (issue) begin
				idx_q <= idx_inc;
				if (last_issue) begin
					drain_q <= 1'b0;
				end
			end
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= idx_q[ffd_pkg::INDEX_W-1:0];
			last_s1 <= last_issue;
		end
		if (pend_s1) begin
			out_index <= idx_s1;
			out_value <= rd_data;
			out_last  <= last_s1;
		end
	end

endmodule

/* rtl/core/fixed_frame_deframer_crc8.sv */
// Top level of the fixed-length serial frame deframer with CRC-8 check.
//
// Input stream: one received serial byte per word on s_axis. The block hunts
// for header FF FC, collects payload_words 32-bit words (little endian), then
// an optional CRC-8 byte (poly 07, init 00, payload only), then tail A1 A2.
// Output stream: each word of a good frame leaves on m_axis with its index;
// tlast marks the final word. Bad or broken frames vanish without output.
// Flow: the input takes a byte whenever s_axis_tready is high. After the
// last tail byte the release request is registered and then the drain
// starts; each word passes the payload RAM's registered read and then the
// output register, and a further RAM read waits until that word has landed.
// While a frame drains, s_axis_tready is low; it rises once the last RAM
// read is issued. A stalled receiver (m_axis_tready low) simply holds the
// output word and pauses the drain. Reset clears the parser to the header
// hunt, empties the output and loads payload_words = 16, crc_check = 1. The
// payload RAM is not cleared; only words written in the current frame are
// ever read. Config (cfg_we/cfg_index/cfg_data) is to be written by the user
// only while no frame drains; the block itself does not enforce this.
module fixed_frame_deframer_crc8 #(
	parameter int unsigned MAX_WORDS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Config write port: index 0 payload_words, index 1 crc_check
	input  logic                               cfg_we,
	input  logic [ffd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ffd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Byte stream in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
	// Word stream out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [39:0]                        m_axis_tdata,  // [3:0] word_index,
	                                                          // [35:4] word_value,
	                                                          // [39:36] zero
	output logic                               m_axis_tlast   // last_word
);

	// Store depth: never more than a frame can release
	localparam int unsigned DEPTH = (MAX_WORDS < ffd_pkg::RESULT_LIMIT) ?
	                                MAX_WORDS : ffd_pkg::RESULT_LIMIT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ffd_pkg::PW_W-1:0]    payload_words_q;
	logic                        crc_check_q;

	logic                        accept;
	logic                        busy;
	ffd_pkg::rel_t               rel;

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [ffd_pkg::WORD_W-1:0]  wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [ffd_pkg::WORD_W-1:0]  rd_data;

	logic [ffd_pkg::INDEX_W-1:0] out_index;
	logic [ffd_pkg::WORD_W-1:0]  out_value;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_words_q <= ffd_pkg::PW_W'(16);
			crc_check_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffd_pkg::REG_PAYLOAD_WORDS: payload_words_q <= cfg_data;
				ffd_pkg::REG_CRC_CHECK:     crc_check_q     <= cfg_data[0];
				default:                    crc_check_q     <= crc_check_q;
			endcase
		end
	end

	// Input is held off only while a released frame is still being read out
	assign s_axis_tready = !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ffd_parse #(
		.DEPTH(DEPTH)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (s_axis_tdata),
		.payload_words (payload_words_q),
		.crc_check     (crc_check_q),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rel           (rel)
	);

	// Payload store: one 32-bit entry per word of the frame
	ffd_ram #(
		.WIDTH(ffd_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ffd_drain #(
		.DEPTH(DEPTH)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.rel       (rel),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_index (out_index),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, out_value, out_index};

endmodule
